[rtl/cees_pkg.sv]
// shared types and constants of the exception-entry sequencer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package cees_pkg;

   // request modes
   typedef enum logic [2:0] {
      MODE_IRQ       = 3'd0,
      MODE_BUS_ERR   = 3'd1,
      MODE_ADDR_ERR  = 3'd2,
      MODE_TRACE     = 3'd3,
      MODE_VECTOR    = 3'd4,
      MODE_SET_OVR   = 3'd5,
      MODE_CLEAR_OVR = 3'd6,
      MODE_UNUSED    = 3'd7
   } mode_type;

   // result kinds
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_WORD  = 2'd1;
   localparam logic [1:0] KIND_LONG  = 2'd2;
   localparam logic [1:0] KIND_FETCH = 2'd3;

   // frame steps, in push order
   typedef enum logic [2:0] {
      STEP_IR    = 3'd0,
      STEP_FAULT = 3'd1,
      STEP_SS    = 3'd2,
      STEP_PC    = 3'd3,
      STEP_SR    = 3'd4,
      STEP_VEC   = 3'd5
   } step_type;

   // status register layout
   localparam int SR_T1_BIT = 15;
   localparam int SR_T0_BIT = 14;
   localparam int SR_S_BIT  = 13;

   // fixed vectors and levels
   localparam logic [7:0] VEC_BUS_ERR  = 8'd2;
   localparam logic [7:0] VEC_ADDR_ERR = 8'd3;
   localparam logic [7:0] VEC_SINGLE_STEP = 8'd9;
   localparam logic [7:0] VEC_AUTO_IRQ = 8'd24;
   localparam logic [7:0] VEC_GROUP0_MAX = 8'd3;
   localparam logic [2:0] LEVEL_NMI    = 3'd7;
   localparam logic [2:0] LEVEL_OVR    = 3'd6;

   // special status word bits
   localparam logic [15:0] SS_READ       = 16'h0010;
   localparam logic [15:0] SS_SUPER_DATA = 16'h0004;

   // cycle charges
   localparam logic [5:0] CYC_GROUP0 = 6'd50;
   localparam logic [5:0] CYC_OTHER  = 6'd34;
   localparam logic [5:0] CYC_NONE   = 6'd0;

   // push sizes
   localparam logic [23:0] DEC_WORD = 24'd2;
   localparam logic [23:0] DEC_LONG = 24'd4;

   // decoded request handed from the decoder to the emitter
   typedef struct packed {
      logic        ack;         // no exception, one kind-0 result
      logic        group0;      // long frame with ir, fault address, ss
      logic [7:0]  vector;
      logic [15:0] new_sr;
      logic [23:0] a7;          // stack pointer before the first push
      logic [23:0] usp;
      logic [5:0]  cyc;
      logic [23:0] pc;
      logic [15:0] old_sr;
      logic [15:0] ir;
      logic [23:0] fault_addr;
      logic        fault_read;
   } job_type;

endpackage

`default_nettype wire

[rtl/cpu_exception_entry_sequencer.sv]
// Exception-entry sequencer of a 68000-class CPU. A request is registered and
// decoded (priority check, override vector, supervisor entry and stack swap),
// then the emitter drives one result transaction per cycle while rsp_tready
// allows: an acknowledge is a single transaction, a short frame is PC, SR,
// vector fetch and a group-0 frame IR, fault address, special status, PC, SR,
// vector fetch. The emitter has a single result register; the next request is
// taken in the cycle the current one's last transaction is loaded, so frames
// follow each other with no gap while rsp_tready stays high.
// uses cees_pkg, cees_decode and cees_emit
`timescale 1ns / 1ps
`default_nettype none

module cpu_exception_entry_sequencer
   import cees_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // mode, irq_level, vector_number, status_in, pc_in, a7_in, ssp_in,
   // user_sp_in, ir_in, fault_addr, fault_was_write, zero fill
   input  wire logic [167:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // kind, bus_address, bus_data, new_status, new_a7, user_sp_out,
   // cycles_charged
   output logic [127:0]      rsp_tdata,
   output logic              rsp_tlast
);

   logic    job_valid;
   logic    job_release;
   job_type job;

   // request register and decode
   cees_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .job_release (job_release),
      .job_valid   (job_valid),
      .job         (job)
   );

   // frame emission
   cees_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_valid),
      .job         (job),
      .job_release (job_release),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

[rtl/cees_decode.sv]
// request decoder: priority check, override state, supervisor entry
// uses cees_pkg; feeds one decoded job register to cees_emit
`timescale 1ns / 1ps
`default_nettype none

module cees_decode
   import cees_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [167:0] req_tdata,
   input  wire logic         job_release,
   output logic              job_valid,
   output job_type           job
);

   logic          job_valid_ff, job_valid_in;
   job_type       job_ff, job_in;
   logic          ovr_valid_ff, ovr_valid_in;
   logic [7:0]    ovr_vector_ff, ovr_vector_in;
   logic          accept;

   // request fields
   mode_type      mode;
   logic [2:0]    irq_level;
   logic [7:0]    vector_number;
   logic [15:0]   status_in;
   logic [23:0]   pc_in, a7_in, ssp_in, user_sp_in, fault_addr;
   logic [15:0]   ir_in;
   logic          fault_was_write;

   logic          irq_take, use_ovr, take;
   logic [7:0]    vector;
   logic [15:0]   sr_now, sr_entry;

   assign mode            = mode_type'(req_tdata[2:0]);
   assign irq_level       = req_tdata[5:3];
   assign vector_number   = req_tdata[13:6];
   assign status_in       = req_tdata[29:14];
   assign pc_in           = req_tdata[53:30];
   assign a7_in           = req_tdata[77:54];
   assign ssp_in          = req_tdata[101:78];
   assign user_sp_in      = req_tdata[125:102];
   assign ir_in           = req_tdata[141:126];
   assign fault_addr      = req_tdata[165:142];
   assign fault_was_write = req_tdata[166];

   // job register frees when its last result is loaded
   assign req_tready = !job_valid_ff || job_release;
   assign accept     = req_tvalid && req_tready;

   // interrupt priority: level 7 always, else above the mask
   assign irq_take = (irq_level != 3'd0) &&
                     ((irq_level == LEVEL_NMI) || (irq_level > status_in[10:8]));
   assign use_ovr  = (irq_level == LEVEL_OVR) && ovr_valid_ff;

   // vector and status selection per mode
   always_comb begin
      take   = 1'b0;
      vector = VEC_BUS_ERR;
      sr_now = status_in;
      unique case (mode)
         MODE_IRQ: begin
            take   = irq_take;
            vector = use_ovr ? ovr_vector_ff : VEC_AUTO_IRQ + {5'd0, irq_level};
            sr_now = {status_in[15:11], irq_level, status_in[7:0]};
         end
         MODE_BUS_ERR: begin
            take   = 1'b1;
            vector = VEC_BUS_ERR;
         end
         MODE_ADDR_ERR: begin
            take   = 1'b1;
            vector = VEC_ADDR_ERR;
         end
         MODE_TRACE: begin
            take   = 1'b1;
            vector = VEC_SINGLE_STEP;
         end
         MODE_VECTOR: begin
            take   = 1'b1;
            vector = vector_number;
         end
         default: begin
            take = 1'b0;
         end
      endcase
   end

   // supervisor entry and job assembly
   always_comb begin
      sr_entry = sr_now;
      sr_entry[SR_S_BIT]  = 1'b1;
      sr_entry[SR_T1_BIT] = 1'b0;
      sr_entry[SR_T0_BIT] = 1'b0;

      job_in            = job_ff;
      job_in.ack        = !take;
      job_in.group0     = (vector == VEC_BUS_ERR) || (vector == VEC_ADDR_ERR);
      job_in.vector     = vector;
      job_in.pc         = pc_in;
      job_in.old_sr     = status_in;
      job_in.ir         = ir_in;
      job_in.fault_addr = fault_addr;
      job_in.fault_read = !fault_was_write;
      if (!take) begin
         job_in.new_sr = status_in;
         job_in.a7     = a7_in;
         job_in.usp    = user_sp_in;
         job_in.cyc    = CYC_NONE;
      end else begin
         job_in.new_sr = sr_entry;
         job_in.a7     = sr_now[SR_S_BIT] ? a7_in : ssp_in;
         job_in.usp    = sr_now[SR_S_BIT] ? user_sp_in : a7_in;
         job_in.cyc    = (vector <= VEC_GROUP0_MAX) ? CYC_GROUP0 : CYC_OTHER;
      end
   end

   // job register handshake
   always_comb begin
      if (accept) begin
         job_valid_in = 1'b1;
      end else if (job_release) begin
         job_valid_in = 1'b0;
      end else begin
         job_valid_in = job_valid_ff;
      end
   end

   // override state updates in acceptance order
   always_comb begin
      ovr_valid_in  = ovr_valid_ff;
      ovr_vector_in = ovr_vector_ff;
      if (accept) begin
         unique case (mode)
            MODE_SET_OVR: begin
               ovr_valid_in  = 1'b1;
               ovr_vector_in = vector_number;
            end
            MODE_CLEAR_OVR: begin
               ovr_valid_in = 1'b0;
            end
            MODE_IRQ: begin
               if (irq_take && use_ovr) begin
                  ovr_valid_in = 1'b0;
               end
            end
            default: begin
               ovr_valid_in = ovr_valid_ff;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff  <= 1'b0;
         ovr_valid_ff  <= 1'b0;
         ovr_vector_ff <= 8'd0;
      end else begin
         job_valid_ff  <= job_valid_in;
         ovr_valid_ff  <= ovr_valid_in;
         ovr_vector_ff <= ovr_vector_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

   // a held job does not change under the emitter
   a_job_hold: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff && !job_release |=> $stable(job_ff) && job_valid_ff)
      else $error("job changed while held");

   // a set request leaves a valid override
   a_ovr_set: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_SET_OVR) |=> ovr_valid_ff)
      else $error("override not recorded");

   // a taken level-6 interrupt consumes the override
   a_ovr_used: assert property (@(posedge clock) disable iff (reset)
      accept && (mode == MODE_IRQ) && irq_take && use_ovr |=> !ovr_valid_ff)
      else $error("override not consumed");

endmodule

`default_nettype wire

[rtl/cees_emit.sv]
// frame emitter: one bus transaction per cycle into the result register
// when it is free; uses cees_pkg; takes decoded jobs from cees_decode
`timescale 1ns / 1ps
`default_nettype none

module cees_emit
   import cees_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         job_valid,
   input  job_type           job,
   output logic              job_release,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [127:0]      rsp_tdata,
   output logic              rsp_tlast
);

   step_type      step_ff, step_in, step_cur;
   logic          first_ff, first_in;
   logic [23:0]   cur_a7_ff, cur_a7_in;
   logic          advance, is_last;

   logic [1:0]    kind;
   logic [23:0]   dec, base_a7, bus_address;
   logic [31:0]   bus_data;
   logic [15:0]   ss_word;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_last_ff;
   logic [1:0]    rsp_kind_ff;
   logic [23:0]   rsp_address_ff, rsp_a7_ff, rsp_usp_ff;
   logic [31:0]   rsp_data_ff;
   logic [15:0]   rsp_status_ff;
   logic [5:0]    rsp_cyc_ff;

   // result register loads when empty or being drained
   assign advance     = job_valid && (!rsp_valid_ff || rsp_tready);
   assign job_release = advance && is_last;

   // a new job starts at its first frame step
   assign step_cur = first_ff ? (job.group0 ? STEP_IR : STEP_PC) : step_ff;
   assign base_a7  = first_ff ? job.a7 : cur_a7_ff;
   assign ss_word  = SS_SUPER_DATA | (job.fault_read ? SS_READ : 16'h0000);

   // next step
   always_comb begin
      unique case (step_cur)
         STEP_IR:    step_in = STEP_FAULT;
         STEP_FAULT: step_in = STEP_SS;
         STEP_SS:    step_in = STEP_PC;
         STEP_PC:    step_in = STEP_SR;
         STEP_SR:    step_in = STEP_VEC;
         default:    step_in = STEP_IR;
      endcase
   end

   // transaction contents of the current step
   always_comb begin
      kind     = KIND_NONE;
      dec      = 24'd0;
      bus_data = 32'd0;
      is_last  = 1'b0;
      if (job.ack) begin
         is_last = 1'b1;
      end else begin
         unique case (step_cur)
            STEP_IR: begin
               kind     = KIND_WORD;
               dec      = DEC_WORD;
               bus_data = {16'd0, job.ir};
            end
            STEP_FAULT: begin
               kind     = KIND_LONG;
               dec      = DEC_LONG;
               bus_data = {8'd0, job.fault_addr};
            end
            STEP_SS: begin
               kind     = KIND_WORD;
               dec      = DEC_WORD;
               bus_data = {16'd0, ss_word};
            end
            STEP_PC: begin
               kind     = KIND_LONG;
               dec      = DEC_LONG;
               bus_data = {8'd0, job.pc};
            end
            STEP_SR: begin
               kind     = KIND_WORD;
               dec      = DEC_WORD;
               bus_data = {16'd0, job.old_sr};
            end
            default: begin
               kind    = KIND_FETCH;
               is_last = 1'b1;
            end
         endcase
      end
      cur_a7_in = base_a7 - dec;
      if (job.ack) begin
         bus_address = 24'd0;
      end else if (kind == KIND_FETCH) begin
         bus_address = {14'd0, job.vector, 2'b00};
      end else begin
         bus_address = cur_a7_in;
      end
   end

   // step tracking
   always_comb begin
      first_in = first_ff;
      if (advance) begin
         first_in = is_last;
      end
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= 1'b1;
         step_ff      <= STEP_IR;
         rsp_valid_ff <= 1'b0;
      end else begin
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            step_ff <= step_in;
         end
      end
   end

   // running stack pointer and result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         cur_a7_ff      <= cur_a7_in;
         rsp_kind_ff    <= kind;
         rsp_address_ff <= bus_address;
         rsp_data_ff    <= bus_data;
         rsp_status_ff  <= job.new_sr;
         rsp_a7_ff      <= cur_a7_in;
         rsp_usp_ff     <= job.usp;
         rsp_cyc_ff     <= job.cyc;
         rsp_last_ff    <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_cyc_ff, rsp_usp_ff, rsp_a7_ff, rsp_status_ff,
                        rsp_data_ff, rsp_address_ff, rsp_kind_ff};

   // the vector fetch always closes a frame
   a_fetch_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_FETCH) |-> rsp_last_ff)
      else $error("vector fetch not marked last");

   // an acknowledge is a lone, free transaction
   a_ack_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_NONE) |-> rsp_last_ff &&
      (rsp_cyc_ff == CYC_NONE))
      else $error("acknowledge malformed");

   // a job leaves only with its last transaction
   a_release_last: assert property (@(posedge clock) disable iff (reset)
      job_release |=> rsp_valid_ff && rsp_last_ff && first_ff)
      else $error("job released early");

endmodule

`default_nettype wire
